>>> rtl/rsks_pkg.sv
// Package for the record sort and key search core: widths, codes and shared types.
`default_nettype none

package rsks_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int KEY_W           = 32;
    localparam int CLS_W           = 16;
    localparam int SLOT_W          = 6;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_EMIT   = 2'd2,
        REQ_SEARCH = 2'd3
    } t_req;

    typedef enum logic {
        KIND_RECORD = 1'b0,
        KIND_SEARCH = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_SEARCH,
        S_FETCH,
        S_ANSWER
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CLS_W-1:0]  cls;
        logic [SLOT_W-1:0] slot;
    } t_rec;

    typedef struct packed {
        logic load;
        logic rotate;
    } t_cell_ctrl;

    typedef struct packed {
        t_kind             kind;
        logic [KEY_W-1:0]  id;
        logic [CLS_W-1:0]  cls;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] pos;
        logic              hit;
        logic              last;
        logic              ovf;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/rsks_if.sv
// Handshake channel interfaces for requests and results.
`default_nettype none

interface rsks_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          req_type;
    logic signed [rsks_pkg::KEY_W-1:0]   record_id;
    logic [rsks_pkg::CLS_W-1:0]          class_number;

    modport source (output valid, req_type, record_id, class_number, input ready);
    modport sink   (input valid, req_type, record_id, class_number, output ready);
endinterface

interface rsks_out_if;
    logic                                valid;
    logic                                ready;
    logic                                result_kind;
    logic signed [rsks_pkg::KEY_W-1:0]   found_id;
    logic [rsks_pkg::CLS_W-1:0]          found_class;
    logic [rsks_pkg::SLOT_W-1:0]         load_slot;
    logic [rsks_pkg::SLOT_W-1:0]         sorted_position;
    logic                                hit;
    logic                                last;
    logic                                overflow;

    modport source (output valid, result_kind, found_id, found_class, load_slot,
                    sorted_position, hit, last, overflow, input ready);
    modport sink   (input valid, result_kind, found_id, found_class, load_slot,
                    sorted_position, hit, last, overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/rsks_cell.sv
// One cell of the sorted record chain: holds one record, compares it, shifts it.
`default_nettype none

module rsks_cell #(
    parameter int MAX_RECORDS = rsks_pkg::MAX_RECORDS_DEF,
    parameter int IDX         = 0
) (
    input  wire                                    i_clk,
    input  wire rsks_pkg::t_cell_ctrl              i_ctrl,
    input  wire [$clog2(MAX_RECORDS+1)-1:0]        i_count,
    input  wire rsks_pkg::t_rec                    i_bcast,
    input  wire rsks_pkg::t_rec                    i_left,
    input  wire                                    i_left_gt,
    input  wire rsks_pkg::t_rec                    i_right,
    input  wire rsks_pkg::t_rec                    i_head,
    output rsks_pkg::t_rec                         o_rec,
    output logic                                   o_gt,
    output logic                                   o_eq
);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    rsks_pkg::t_rec r_rec;
    logic           w_occ;
    logic           w_tail;
    logic           w_wrap;

    assign w_occ  = CW'(IDX) < i_count;
    assign w_tail = i_count == CW'(IDX);
    assign w_wrap = i_count == CW'(IDX + 1);

    assign o_gt  = w_occ && ($signed(r_rec.key) > $signed(i_bcast.key));
    assign o_eq  = w_occ && (r_rec.key == i_bcast.key);
    assign o_rec = r_rec;

    // On a load every cell past the insertion point takes its left neighbor,
    // the insertion cell takes the new record. Rotation moves toward cell 0
    // and the last occupied cell picks up the old head.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && (o_gt || w_tail)) begin
            r_rec <= i_left_gt ? i_left : i_bcast;
        end else if (i_ctrl.rotate) begin
            r_rec <= w_wrap ? i_head : i_right;
        end
    end

endmodule

`default_nettype wire

>>> rtl/record_sort_and_key_search_core.sv
// Top level: chain of sorted record cells with clear, load, emit and binary search control.
//
//  channel  | modport | beat contents
//  ---------+---------+---------------------------------------------------------
//  i_req    | sink    | req_type, record_id, class_number
//  o_res    | source  | result_kind, found_id, found_class, load_slot,
//           |         | sorted_position, hit, last, overflow
//
// A load inserts in parallel across the chain.
// An emit of N records rotates the chain one step per beat.
// Search probes the midpoint of a binary interval; a miss ends when the interval is empty,
// a hit rotates the chain to fetch the record, and the answer beat follows.
// Reset is synchronous, active low, and empties the table; no clearing pass.
// A stalled result holds the rotation of an emit; requests wait until idle.
`default_nettype none

module record_sort_and_key_search_core #(
    parameter int MAX_RECORDS = rsks_pkg::MAX_RECORDS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    rsks_in_if.sink      i_req,
    rsks_out_if.source   o_res
);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    rsks_pkg::t_state     r_state, n_state;
    logic [CW-1:0]        r_count;
    logic                 r_ovf;
    logic [IW-1:0]        r_idx;
    logic [rsks_pkg::KEY_W-1:0] r_key;
    logic [CW-1:0]        r_lo, r_hie;
    logic [IW-1:0]        r_mid;
    logic                 r_hit;
    logic [rsks_pkg::CLS_W-1:0]  r_cls;
    logic [rsks_pkg::SLOT_W-1:0] r_slot;
    rsks_pkg::t_res       r_res;
    logic                 r_out_valid;

    rsks_pkg::t_req       w_req;
    logic                 w_acc;
    logic                 w_out_free;
    logic                 w_full;
    logic                 w_last_idx;
    logic [CW:0]          w_sum;
    logic [IW-1:0]        w_mid;
    logic                 w_probe;
    logic                 w_emit_load;
    logic                 w_ans_load;
    rsks_pkg::t_cell_ctrl w_ctrl;
    rsks_pkg::t_rec       w_bcast;
    rsks_pkg::t_rec       w_rec [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] w_gt;
    logic [MAX_RECORDS-1:0] w_eq;

    assign w_req      = rsks_pkg::t_req'(i_req.req_type);
    assign i_req.ready = (r_state == rsks_pkg::S_IDLE);
    assign w_acc      = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_full     = r_count == CW'(MAX_RECORDS);
    assign w_last_idx = (CW'(r_idx) + CW'(1)) == r_count;

    // Probe midpoint of the live interval [lo, hie); only used while lo < hie.
    assign w_sum   = (CW+1)'(r_lo) + (CW+1)'(r_hie) - (CW+1)'(1);
    assign w_mid   = w_sum[IW:1];
    assign w_probe = r_lo < r_hie;

    assign w_emit_load = (r_state == rsks_pkg::S_EMIT) && w_out_free;
    assign w_ans_load  = (r_state == rsks_pkg::S_ANSWER) && w_out_free;

    assign w_ctrl.load   = w_acc && (w_req == rsks_pkg::REQ_LOAD) && !w_full;
    assign w_ctrl.rotate = w_emit_load || (r_state == rsks_pkg::S_FETCH);

    assign w_bcast.key  = (r_state == rsks_pkg::S_IDLE) ? i_req.record_id : r_key;
    assign w_bcast.cls  = i_req.class_number;
    assign w_bcast.slot = rsks_pkg::SLOT_W'(r_count);

    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        rsks_pkg::t_rec w_left;
        rsks_pkg::t_rec w_right;
        logic           w_left_gt;

        if (g == 0) begin : g_first
            assign w_left    = w_bcast;
            assign w_left_gt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_rec[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == MAX_RECORDS - 1) begin : g_end
            assign w_right = w_rec[0];
        end else begin : g_inner
            assign w_right = w_rec[g+1];
        end

        rsks_cell #(
            .MAX_RECORDS (MAX_RECORDS),
            .IDX         (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_count   (r_count),
            .i_bcast   (w_bcast),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .i_head    (w_rec[0]),
            .o_rec     (w_rec[g]),
            .o_gt      (w_gt[g]),
            .o_eq      (w_eq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsks_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rsks_pkg::S_IDLE: begin
                if (w_acc) begin
                    case (w_req)
                        rsks_pkg::REQ_EMIT: begin
                            if (r_count != '0) n_state = rsks_pkg::S_EMIT;
                        end
                        rsks_pkg::REQ_SEARCH: n_state = rsks_pkg::S_SEARCH;
                        default:              n_state = rsks_pkg::S_IDLE;
                    endcase
                end
            end
            rsks_pkg::S_EMIT: begin
                if (w_out_free && w_last_idx) n_state = rsks_pkg::S_IDLE;
            end
            rsks_pkg::S_SEARCH: begin
                if (!w_probe) begin
                    n_state = rsks_pkg::S_ANSWER;
                end else if (w_eq[w_mid]) begin
                    n_state = rsks_pkg::S_FETCH;
                end
            end
            rsks_pkg::S_FETCH: begin
                if (w_last_idx) n_state = rsks_pkg::S_ANSWER;
            end
            rsks_pkg::S_ANSWER: begin
                if (w_out_free) n_state = rsks_pkg::S_IDLE;
            end
            default: n_state = rsks_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc && (w_req == rsks_pkg::REQ_CLEAR)) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (w_acc && (w_req == rsks_pkg::REQ_LOAD)) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end

            if (w_emit_load || w_ans_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_idx <= '0;
            r_key <= i_req.record_id;
            r_lo  <= '0;
            r_hie <= r_count;
            r_hit <= 1'b0;
        end

        if (r_state == rsks_pkg::S_SEARCH && w_probe) begin
            if (w_eq[w_mid]) begin
                r_mid <= w_mid;
                r_hit <= 1'b1;
                r_idx <= '0;
            end else if (w_gt[w_mid]) begin
                r_hie <= CW'(w_mid);
            end else begin
                r_lo <= CW'(w_mid) + CW'(1);
            end
        end

        if (w_emit_load || r_state == rsks_pkg::S_FETCH) begin
            r_idx <= r_idx + IW'(1);
        end

        if (r_state == rsks_pkg::S_FETCH && r_idx == r_mid) begin
            r_cls  <= w_rec[0].cls;
            r_slot <= w_rec[0].slot;
        end

        if (w_emit_load) begin
            r_res.kind <= rsks_pkg::KIND_RECORD;
            r_res.id   <= w_rec[0].key;
            r_res.cls  <= w_rec[0].cls;
            r_res.slot <= w_rec[0].slot;
            r_res.pos  <= rsks_pkg::SLOT_W'(r_idx);
            r_res.hit  <= 1'b1;
            r_res.last <= w_last_idx;
            r_res.ovf  <= r_ovf;
        end else if (w_ans_load) begin
            r_res.kind <= rsks_pkg::KIND_SEARCH;
            r_res.id   <= r_hit ? r_key : '0;
            r_res.cls  <= r_hit ? r_cls : '0;
            r_res.slot <= r_hit ? r_slot : '0;
            r_res.pos  <= r_hit ? rsks_pkg::SLOT_W'(r_mid) : '0;
            r_res.hit  <= r_hit;
            r_res.last <= 1'b1;
            r_res.ovf  <= r_ovf;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.result_kind     = r_res.kind;
    assign o_res.found_id        = r_res.id;
    assign o_res.found_class     = r_res.cls;
    assign o_res.load_slot       = r_res.slot;
    assign o_res.sorted_position = r_res.pos;
    assign o_res.hit             = r_res.hit;
    assign o_res.last            = r_res.last;
    assign o_res.overflow        = r_res.ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RECORDS))
        else $error("record count above table size");

    a_full_load_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_req == rsks_pkg::REQ_LOAD && w_full) |=> r_ovf)
        else $error("load into full table did not set overflow");

    a_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsks_pkg::S_SEARCH) |-> (r_lo <= r_hie && r_hie <= r_count))
        else $error("search interval out of range");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit_load && w_last_idx) |=> (r_state == rsks_pkg::S_IDLE && r_res.last))
        else $error("emit run did not end on its last beat");

    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_req == rsks_pkg::REQ_EMIT && r_count != '0)
            |=> (r_state == rsks_pkg::S_EMIT && r_idx == '0))
        else $error("emit run did not start at the head");

endmodule

`default_nettype wire

>>> tb/sv/rsks_checker.sv
`timescale 1ns / 100ps
// Checker for the record table core: predicts every answer from accepted requests and compares.
module rsks_checker
    import rsks_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rsks_in_if   i_req_mon,
    rsks_out_if  i_res_mon,
    output int   o_fail_count,
    output int   o_pending
);

    logic signed [KEY_W-1:0] key_tab  [MAX_RECORDS];
    logic [CLS_W-1:0]        cls_tab  [MAX_RECORDS];
    logic [SLOT_W-1:0]       slot_tab [MAX_RECORDS];
    int                      rec_count;
    logic                    ovf_flag;
    t_res                    answer_q [$];
    int                      fail_count;

    function automatic t_res make_answer(t_kind kind, logic [KEY_W-1:0] id,
                                         logic [CLS_W-1:0] cls, logic [SLOT_W-1:0] slot,
                                         logic [SLOT_W-1:0] pos, logic hit, logic last);
        t_res r;
        r.kind = kind;
        r.id   = id;
        r.cls  = cls;
        r.slot = slot;
        r.pos  = pos;
        r.hit  = hit;
        r.last = last;
        r.ovf  = ovf_flag;
        return r;
    endfunction

    // Updates the table for one request and queues the beats it must produce.
    task automatic apply_request(t_req req, logic signed [KEY_W-1:0] id,
                                 logic [CLS_W-1:0] cls);
        int p;
        int low;
        int high;
        int mid;
        bit matched;
        case (req)
            REQ_CLEAR: begin
                rec_count = 0;
                ovf_flag  = 1'b0;
            end
            REQ_LOAD: begin
                if (rec_count >= MAX_RECORDS) begin
                    ovf_flag = 1'b1;
                end else begin
                    // Equal ids stay in load order: insert after every id <= the new one.
                    p = rec_count;
                    while (p > 0 && key_tab[p-1] > id) begin
                        key_tab[p]  = key_tab[p-1];
                        cls_tab[p]  = cls_tab[p-1];
                        slot_tab[p] = slot_tab[p-1];
                        p--;
                    end
                    key_tab[p]  = id;
                    cls_tab[p]  = cls;
                    slot_tab[p] = SLOT_W'(rec_count);
                    rec_count++;
                end
            end
            REQ_EMIT: begin
                for (int i = 0; i < rec_count; i++) begin
                    answer_q.push_back(make_answer(KIND_RECORD, key_tab[i], cls_tab[i],
                                                   slot_tab[i], SLOT_W'(i), 1'b1,
                                                   i == rec_count - 1));
                end
            end
            default: begin
                low     = 0;
                high    = rec_count - 1;
                matched = 1'b0;
                while (low <= high && !matched) begin
                    mid = (low + high) / 2;
                    if (key_tab[mid] == id) begin
                        answer_q.push_back(make_answer(KIND_SEARCH, key_tab[mid], cls_tab[mid],
                                                       slot_tab[mid], SLOT_W'(mid), 1'b1,
                                                       1'b1));
                        matched = 1'b1;
                    end else if (key_tab[mid] > id) begin
                        high = mid - 1;
                    end else begin
                        low = mid + 1;
                    end
                end
                if (!matched) begin
                    answer_q.push_back(make_answer(KIND_SEARCH, '0, '0, '0, '0, 1'b0, 1'b1));
                end
            end
        endcase
    endtask

    task automatic flag_failure(string why, t_res got, t_res want);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $realtime, why);
            $display("    got  kind=%0d id=%0d cls=%0h slot=%0d pos=%0d hit=%0d last=%0d ovf=%0d",
                     got.kind, $signed(got.id), got.cls, got.slot, got.pos, got.hit,
                     got.last, got.ovf);
            $display("    want kind=%0d id=%0d cls=%0h slot=%0d pos=%0d hit=%0d last=%0d ovf=%0d",
                     want.kind, $signed(want.id), want.cls, want.slot, want.pos, want.hit,
                     want.last, want.ovf);
        end
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            rec_count  = 0;
            ovf_flag   = 1'b0;
            fail_count = 0;
            answer_q.delete();
        end else begin
            // Result beats first: a beat leaving on this edge belongs to an older request.
            if (i_res_mon.valid && i_res_mon.ready) begin
                got.kind = t_kind'(i_res_mon.result_kind);
                got.id   = i_res_mon.found_id;
                got.cls  = i_res_mon.found_class;
                got.slot = i_res_mon.load_slot;
                got.pos  = i_res_mon.sorted_position;
                got.hit  = i_res_mon.hit;
                got.last = i_res_mon.last;
                got.ovf  = i_res_mon.overflow;
                if (answer_q.size() == 0) begin
                    flag_failure("result beat with nothing expected", got, '0);
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        flag_failure("result beat differs from prediction", got, want);
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                apply_request(t_req'(i_req_mon.req_type), i_req_mon.record_id,
                              i_req_mon.class_number);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= answer_q.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench top: drives requests and result back-pressure, and gives the verdict.
module testbench;
    import rsks_pkg::*;

    localparam int RANDOM_ITEMS = 160;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 120;

    logic i_clk;
    logic i_rst_n;

    rsks_in_if  req_if ();
    rsks_out_if res_if ();

    int fail_count;
    int pending;

    record_sort_and_key_search_core #(
        .MAX_RECORDS (MAX_RECORDS_DEF)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    rsks_checker #(
        .MAX_RECORDS (MAX_RECORDS_DEF)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_if),
        .i_res_mon    (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    bit                      long_hold_req;
    int                      burst_left;
    int                      items_sent;
    logic signed [KEY_W-1:0] stored_ids [$];

    // Ids come often from a small pool so that duplicates and extremes recur.
    function automatic logic signed [KEY_W-1:0] pick_id();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return 32'sd7;
            5:       return -32'sd300;
            6:       return 32'sd12345;
            7:       return 32'sh4000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [KEY_W-1:0] search_target();
        if (stored_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
            return stored_ids[$urandom_range(0, stored_ids.size() - 1)];
        end
        return pick_id();
    endfunction

    // Offers one request beat and returns on the edge where it is accepted.
    task automatic send_req(t_req req, logic signed [KEY_W-1:0] id, logic [CLS_W-1:0] cls);
        int gap;
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        req_if.valid        <= 1'b1;
        req_if.req_type     <= req;
        req_if.record_id    <= id;
        req_if.class_number <= cls;
        do @(posedge i_clk); while (!req_if.ready);
        items_sent++;
        if (req == REQ_LOAD) begin
            stored_ids.push_back(id);
        end else if (req == REQ_CLEAR) begin
            stored_ids.delete();
        end
    endtask

    // Result side: stall patterns of varying density, plus one long hold-off on request.
    initial begin
        int  stall_mode;
        int  stall_run;
        bit  hold_done;
        stall_run        = 0;
        hold_done        = 1'b0;
        res_if.ready    <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !hold_done) begin
                res_if.ready <= 1'b0;
                hold_done = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (stall_run == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    stall_run  = $urandom_range(5, 40);
                end
                stall_run--;
                case (stall_mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= ($urandom_range(0, 3) != 0);
                    default: res_if.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int first_random;
        int n_loads;
        int n_searches;
        long_hold_req        = 1'b0;
        burst_left           = 0;
        items_sent           = 0;
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= REQ_CLEAR;
        req_if.record_id    <= '0;
        req_if.class_number <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extreme ids and classes, duplicates, hits, misses, clear.
        send_req(REQ_SEARCH, 32'sd0, 16'h0000);
        send_req(REQ_EMIT, 32'sd0, 16'h0000);
        send_req(REQ_LOAD, 32'sh7FFF_FFFF, 16'hFFFF);
        send_req(REQ_LOAD, 32'sh8000_0000, 16'h0000);
        send_req(REQ_LOAD, 32'sd0, 16'h5555);
        send_req(REQ_LOAD, -32'sd1, 16'hAAAA);
        send_req(REQ_LOAD, 32'sd5, 16'h0001);
        send_req(REQ_LOAD, 32'sd5, 16'h0002);
        send_req(REQ_LOAD, 32'sd5, 16'h0003);
        send_req(REQ_EMIT, 32'sd0, 16'h0000);
        send_req(REQ_SEARCH, 32'sh8000_0000, 16'h0000);
        send_req(REQ_SEARCH, 32'sh7FFF_FFFF, 16'hFFFF);
        send_req(REQ_SEARCH, 32'sd5, 16'h0000);
        send_req(REQ_SEARCH, -32'sd1, 16'h0000);
        send_req(REQ_SEARCH, 32'sd1, 16'h0000);
        send_req(REQ_SEARCH, 32'sh8000_0001, 16'h0000);
        send_req(REQ_CLEAR, 32'sd0, 16'h0000);
        send_req(REQ_EMIT, 32'sd0, 16'h0000);
        send_req(REQ_SEARCH, 32'sd5, 16'h0000);
        send_req(REQ_LOAD, 32'sd3, 16'h0007);
        send_req(REQ_EMIT, 32'sd0, 16'h0000);

        // Fill the table past its size so the overflow flag rises, then hold the
        // result side while a full emit stalls and further searches wait at the input.
        first_random = items_sent;
        send_req(REQ_CLEAR, $urandom, 16'($urandom));
        for (int i = 0; i < MAX_RECORDS_DEF + 2; i++) begin
            send_req(REQ_LOAD, pick_id(), 16'($urandom));
        end
        send_req(REQ_EMIT, $urandom, 16'($urandom));
        long_hold_req = 1'b1;
        repeat (3) send_req(REQ_SEARCH, search_target(), 16'($urandom));

        while (items_sent - first_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                send_req(t_req'($urandom_range(0, 3)), $urandom, 16'($urandom));
            end else begin
                if ($urandom_range(0, 9) < 7) begin
                    send_req(REQ_CLEAR, $urandom, 16'($urandom));
                end
                n_loads = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
                repeat (n_loads) send_req(REQ_LOAD, pick_id(), 16'($urandom));
                send_req(REQ_EMIT, $urandom, 16'($urandom));
                n_searches = $urandom_range(1, 4);
                repeat (n_searches) send_req(REQ_SEARCH, search_target(), 16'($urandom));
            end
        end
        req_if.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/rsks_pkg.sv
rtl/rsks_if.sv
rtl/rsks_cell.sv
rtl/record_sort_and_key_search_core.sv
tb/sv/rsks_checker.sv
tb/sv/testbench.sv
